FILE: hdl/takf_pkg.sv
// ----------------------------------------------------------------------------
// Tilt-angle Kalman filter package
// Shared constants, opcodes and Q16.32 saturating helpers.
// ----------------------------------------------------------------------------
package takf_pkg;

    localparam int unsigned DW = 48;
    localparam int unsigned CW = 47;
    localparam int unsigned AXES_DEF = 2;

    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] ONE_Q = 48'h0001_0000_0000;

    localparam logic [CW-1:0] QA_RST = 47'd4294967;
    localparam logic [CW-1:0] QB_RST = 47'd12884902;
    localparam logic [CW-1:0] RN_RST = 47'd2147483648;
    localparam logic [CW-1:0] DT_RST = 47'd42949673;

    localparam logic [1:0] REG_QA = 2'd0;
    localparam logic [1:0] REG_QB = 2'd1;
    localparam logic [1:0] REG_RN = 2'd2;
    localparam logic [1:0] REG_DT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ADD, ST_MUL, ST_MULW, ST_DIV, ST_DIVW, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_ADD, OP_SUB
    } aop_t;

    // saturating add/sub on 48-bit signed
    function automatic logic [DW-1:0] sat_addsub(input logic [DW-1:0] a,
                                                 input logic [DW-1:0] b,
                                                 input aop_t op);
        logic signed [DW:0] s;
        s = (op == OP_SUB) ? ($signed({a[DW-1], a}) - $signed({b[DW-1], b}))
                           : ($signed({a[DW-1], a}) + $signed({b[DW-1], b}));
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? SMIN : SMAX;
        end
        return s[DW-1:0];
    endfunction

    // apply sign to magnitude with saturation
    function automatic logic [DW-1:0] apply_sign(input logic [63:0] m, input logic neg);
        if (neg) begin
            if (m >= 64'h0000_8000_0000_0000) begin
                return SMIN;
            end
            return DW'(-m);
        end
        if (m > 64'h0000_7FFF_FFFF_FFFF) begin
            return SMAX;
        end
        return m[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] magn(input logic [DW-1:0] a);
        return a[DW-1] ? DW'(-a) : a;
    endfunction

endpackage

FILE: hdl/takf_mul.sv
// ----------------------------------------------------------------------------
// Q16.32 multiplier
// Signed saturating multiply, rounded to nearest, over four partial products.
// ----------------------------------------------------------------------------
module takf_mul (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [takf_pkg::DW-1:0]   op_a,
    input  logic [takf_pkg::DW-1:0]   op_b,
    output logic                      done,
    output logic [takf_pkg::DW-1:0]   result
);
    logic [2:0]  step_reg, step_next;
    logic [47:0] ua_reg, ub_reg;
    logic        neg_reg;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] ma, mb;
    logic [63:0] pp;

    // pick partial product per step: al*bl, ah*bl, al*bh, ah*bh
    always_comb begin
        unique case (step_reg)
            3'd1: begin ma = ua_reg[31:0];         mb = ub_reg[31:0]; end
            3'd2: begin ma = {16'd0, ua_reg[47:32]}; mb = ub_reg[31:0]; end
            3'd3: begin ma = ua_reg[31:0];         mb = {16'd0, ub_reg[47:32]}; end
            default: begin ma = {16'd0, ua_reg[47:32]}; mb = {16'd0, ub_reg[47:32]}; end
        endcase
        pp = 64'(ma) * 64'(mb);
        unique case (step_reg)
            3'd1:    acc_next = (pp + 64'h8000_0000) >> 32;
            3'd2,
            3'd3:    acc_next = acc_reg + pp;
            3'd4:    acc_next = acc_reg + (pp << 32);
            default: acc_next = acc_reg;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        if (start) begin
            step_next = 3'd1;
        end else if (step_reg != 3'd0 && step_reg != 3'd5) begin
            step_next = step_reg + 3'd1;
        end else if (step_reg == 3'd5) begin
            step_next = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 3'd0;
        end else begin
            step_reg <= step_next;
        end
        if (start) begin
            ua_reg  <= takf_pkg::magn(op_a);
            ub_reg  <= takf_pkg::magn(op_b);
            neg_reg <= op_a[47] ^ op_b[47];
        end
        acc_reg <= acc_next;
    end

    assign done   = (step_reg == 3'd5);
    assign result = takf_pkg::apply_sign(acc_reg, neg_reg);
endmodule

FILE: hdl/takf_div.sv
// ----------------------------------------------------------------------------
// Q16.32 divider
// Restoring divide, one quotient bit a cycle, truncated and saturated; a zero divisor gives 0.
// ----------------------------------------------------------------------------
module takf_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [takf_pkg::DW-1:0]   num,
    input  logic [takf_pkg::DW-1:0]   den,
    output logic                      done,
    output logic [takf_pkg::DW-1:0]   result
);
    // quotient of (|n| << 32) / |d|, 80 bits, one bit a step
    localparam int unsigned QW = 80;
    logic [6:0]    cnt_reg;
    logic          busy_reg, done_reg;
    logic [QW-1:0] q_reg;
    logic [48:0]   r_reg;
    logic [47:0]   d_reg;
    logic          neg_reg, zero_reg;
    logic [48:0]   r_sh;
    logic          ge;

    assign r_sh = {r_reg[47:0], q_reg[QW-1]};
    assign ge   = r_sh >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 7'(QW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        if (start) begin
            cnt_reg  <= 7'd0;
            q_reg    <= {takf_pkg::magn(num), 32'd0};
            r_reg    <= 49'd0;
            d_reg    <= takf_pkg::magn(den);
            neg_reg  <= num[47] ^ den[47];
            zero_reg <= (den == 48'd0);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 7'd1;
            r_reg   <= ge ? (r_sh - {1'b0, d_reg}) : r_sh;
            q_reg   <= {q_reg[QW-2:0], ge};
        end
    end

    always_comb begin
        if (zero_reg) begin
            result = '0;
        end else if (q_reg[QW-1:47] != '0) begin
            result = takf_pkg::apply_sign(64'h0000_8000_0000_0000, neg_reg);
        end else begin
            result = takf_pkg::apply_sign({17'd0, q_reg[46:0]}, neg_reg);
        end
    end
    assign done = done_reg;
endmodule

FILE: hdl/tilt_angle_kalman_filter_unit.sv
// ----------------------------------------------------------------------------
// Tilt-angle Kalman filter unit
// Two-state angle/gyro-bias Kalman filter with separate state per axis.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis request: tdata = {rate_in, measured_angle, axis} (axis lowest).
//   m_axis result: tdata = {corrected_rate, filtered_angle}, one per request.
//   Config: cfg_wen/cfg_index/cfg_wdata write Qa, Qb, R, dt; write when idle.
// Datapath:
//   Each request runs a small microcode of 23 steps through one shared
//   saturating adder, one multiplier (four partial products) and one
//   restoring divider; the two divisions dominate. s_tready is low from
//   acceptance until the result is loaded, so a new request is not taken
//   before the last one is through the sequencer.
// Reset:
//   aresetn (sync, active low) restores default noises and dt, and clears
//   the per-axis state to angle 0, bias 0, identity covariance.
// Stall:
//   The result holds in the output register until m_tready. A new request
//   may be taken while it waits; the next result holds in the sequencer
//   until the output register is free, and s_tready stays low until then.
// ----------------------------------------------------------------------------
module tilt_angle_kalman_filter_unit #(
    parameter int unsigned AXES = takf_pkg::AXES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // axis[0], measured_angle[48:1], rate_in[96:49]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,   // filtered_angle[47:0], corrected_rate[95:48]
    input  logic          cfg_wen,
    input  logic [1:0]    cfg_index,
    input  logic [46:0]   cfg_wdata
);
    localparam int unsigned AW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int unsigned DW = takf_pkg::DW;

    // register file slots
    localparam logic [3:0] R_A = 4'd0, R_B = 4'd1, R_P00 = 4'd2, R_P01 = 4'd3,
        R_P10 = 4'd4, R_P11 = 4'd5, R_MEAS = 4'd6, R_RATE = 4'd7, R_T0 = 4'd8,
        R_T1 = 4'd9, R_E = 4'd10, R_K0 = 4'd11, R_K1 = 4'd12, R_ERR = 4'd13,
        R_X = 4'd14, R_Z = 4'd15;
    // source-only slots (above 15): qa, qb, rn, dt
    localparam logic [4:0] S_QA = 5'd16, S_QB = 5'd17, S_RN = 5'd18, S_DT = 5'd19;

    typedef enum logic [1:0] {K_ADD, K_SUB, K_MUL, K_DIV} kind_t;
    typedef struct packed {
        kind_t      kind;
        logic [4:0] sa;
        logic [4:0] sb;
        logic [3:0] dst;
        logic       acc;  // multiply result added to dst (sub if acc_sub)
        logic       acc_sub;
    } uop_t;

    function automatic uop_t rom(input logic [4:0] pc);
        uop_t u;
        u = '{K_ADD, 5'd0, 5'd0, 4'd0, 1'b0, 1'b0};
        unique case (pc)
            5'd0:  u = '{K_SUB, 5'(R_RATE), 5'(R_B),   R_X,   1'b0, 1'b0};
            5'd1:  u = '{K_MUL, 5'(R_X),    S_DT,      R_A,   1'b1, 1'b0};
            5'd2:  u = '{K_SUB, S_QA,       5'(R_P01), R_X,   1'b0, 1'b0};
            5'd3:  u = '{K_SUB, 5'(R_X),    5'(R_P10), R_X,   1'b0, 1'b0};
            5'd4:  u = '{K_SUB, 5'(R_Z),    5'(R_P11), R_T1,  1'b0, 1'b0};
            5'd5:  u = '{K_MUL, 5'(R_X),    S_DT,      R_P00, 1'b1, 1'b0};
            5'd6:  u = '{K_MUL, 5'(R_T1),   S_DT,      R_X,   1'b0, 1'b0};
            5'd7:  u = '{K_ADD, 5'(R_P01),  5'(R_X),   R_P01, 1'b0, 1'b0};
            5'd8:  u = '{K_ADD, 5'(R_P10),  5'(R_X),   R_P10, 1'b0, 1'b0};
            5'd9:  u = '{K_MUL, S_QB,       S_DT,      R_P11, 1'b1, 1'b0};
            5'd10: u = '{K_SUB, 5'(R_MEAS), 5'(R_A),   R_ERR, 1'b0, 1'b0};
            5'd11: u = '{K_ADD, S_RN,       5'(R_P00), R_E,   1'b0, 1'b0};
            5'd12: u = '{K_DIV, 5'(R_P00),  5'(R_E),   R_K0,  1'b0, 1'b0};
            5'd13: u = '{K_DIV, 5'(R_P10),  5'(R_E),   R_K1,  1'b0, 1'b0};
            5'd14: u = '{K_ADD, 5'(R_P00),  5'(R_Z),   R_T0,  1'b0, 1'b0};
            5'd15: u = '{K_ADD, 5'(R_P01),  5'(R_Z),   R_T1,  1'b0, 1'b0};
            5'd16: u = '{K_MUL, 5'(R_K0),   5'(R_T0),  R_P00, 1'b1, 1'b1};
            5'd17: u = '{K_MUL, 5'(R_K0),   5'(R_T1),  R_P01, 1'b1, 1'b1};
            5'd18: u = '{K_MUL, 5'(R_K1),   5'(R_T0),  R_P10, 1'b1, 1'b1};
            5'd19: u = '{K_MUL, 5'(R_K1),   5'(R_T1),  R_P11, 1'b1, 1'b1};
            5'd20: u = '{K_MUL, 5'(R_K0),   5'(R_ERR), R_A,   1'b1, 1'b0};
            5'd21: u = '{K_MUL, 5'(R_K1),   5'(R_ERR), R_B,   1'b1, 1'b0};
            5'd22: u = '{K_SUB, 5'(R_RATE), 5'(R_B),   R_X,   1'b0, 1'b0};
            default: u = '{K_ADD, 5'(R_A),  5'(R_Z),   R_A,   1'b0, 1'b0};
        endcase
        return u;
    endfunction

    localparam logic [4:0] LAST_PC = 5'd22;

    // configuration
    logic [46:0] qa_reg, qb_reg, rn_reg, dt_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qa_reg <= takf_pkg::QA_RST;
            qb_reg <= takf_pkg::QB_RST;
            rn_reg <= takf_pkg::RN_RST;
            dt_reg <= takf_pkg::DT_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                takf_pkg::REG_QA: qa_reg <= cfg_wdata;
                takf_pkg::REG_QB: qb_reg <= cfg_wdata;
                takf_pkg::REG_RN: rn_reg <= cfg_wdata;
                default:          dt_reg <= cfg_wdata;
            endcase
        end
    end

    // per-axis state
    logic [DW-1:0] st_a_reg [AXES], st_b_reg [AXES], st_p00_reg [AXES],
                   st_p01_reg [AXES], st_p10_reg [AXES], st_p11_reg [AXES];
    logic [DW-1:0] rf_reg [16];
    logic [AW-1:0] ax_reg;
    logic [AW-1:0] ax_in;

    takf_pkg::state_t state_reg, state_next;
    logic [4:0] pc_reg, pc_next;
    logic [95:0] out_reg;
    logic        out_valid_reg, out_valid_next;

    uop_t u;
    logic [DW-1:0] va, vb, alu_a, alu_b, alu_y;
    takf_pkg::aop_t alu_op;
    logic mul_start, mul_done, div_start, div_done;
    logic [DW-1:0] mul_y, div_y;
    logic wr_en;
    logic [DW-1:0] wr_val;

    function automatic logic [DW-1:0] src(input logic [4:0] s,
                                          input logic [DW-1:0] rf [16],
                                          input logic [46:0] qa, input logic [46:0] qb,
                                          input logic [46:0] rn, input logic [46:0] dt);
        if (s[4]) begin
            unique case (s[1:0])
                2'd0:    return {1'b0, qa};
                2'd1:    return {1'b0, qb};
                2'd2:    return {1'b0, rn};
                default: return {1'b0, dt};
            endcase
        end
        return rf[s[3:0]];
    endfunction

    // a one-bit axis number is always below AXES when AXES is two or more
    if (AXES > 1) begin : g_ax
        assign ax_in = AW'(s_tdata[0]);
    end else begin : g_ax1
        assign ax_in = 1'b0 & s_tdata[0];
    end

    always_comb begin
        u  = rom(pc_reg);
        va = src(u.sa, rf_reg, qa_reg, qb_reg, rn_reg, dt_reg);
        vb = src(u.sb, rf_reg, qa_reg, qb_reg, rn_reg, dt_reg);
        // shared adder: plain ops, or accumulate of a product into dst
        if (state_reg == takf_pkg::ST_MULW) begin
            alu_a  = rf_reg[u.dst];
            alu_b  = mul_y;
            alu_op = u.acc_sub ? takf_pkg::OP_SUB : takf_pkg::OP_ADD;
        end else begin
            alu_a  = va;
            alu_b  = vb;
            alu_op = (u.kind == K_SUB) ? takf_pkg::OP_SUB : takf_pkg::OP_ADD;
        end
        alu_y = takf_pkg::sat_addsub(alu_a, alu_b, alu_op);
    end

    takf_mul u_mul (.aclk, .aresetn, .start(mul_start), .op_a(va), .op_b(vb),
                    .done(mul_done), .result(mul_y));
    takf_div u_div (.aclk, .aresetn, .start(div_start), .num(va), .den(vb),
                    .done(div_done), .result(div_y));

    // sequencer
    always_comb begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        wr_en          = 1'b0;
        wr_val         = alu_y;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            takf_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = takf_pkg::ST_ADD;
                    pc_next    = 5'd0;
                end
            end
            takf_pkg::ST_ADD: begin
                unique case (u.kind)
                    K_MUL: begin
                        mul_start  = 1'b1;
                        state_next = takf_pkg::ST_MUL;
                    end
                    K_DIV: begin
                        div_start  = 1'b1;
                        state_next = takf_pkg::ST_DIV;
                    end
                    default: begin
                        wr_en = 1'b1;
                        if (pc_reg == LAST_PC) begin
                            state_next = takf_pkg::ST_OUT;
                        end else begin
                            pc_next = pc_reg + 5'd1;
                        end
                    end
                endcase
            end
            takf_pkg::ST_MUL: begin
                if (mul_done) begin
                    if (u.acc) begin
                        state_next = takf_pkg::ST_MULW;
                    end else begin
                        wr_en      = 1'b1;
                        wr_val     = mul_y;
                        pc_next    = pc_reg + 5'd1;
                        state_next = takf_pkg::ST_ADD;
                    end
                end
            end
            takf_pkg::ST_MULW: begin
                wr_en      = 1'b1;
                pc_next    = pc_reg + 5'd1;
                state_next = takf_pkg::ST_ADD;
            end
            takf_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = takf_pkg::ST_DIVW;
                end
            end
            takf_pkg::ST_DIVW: begin
                wr_en      = 1'b1;
                wr_val     = div_y;
                pc_next    = pc_reg + 5'd1;
                state_next = takf_pkg::ST_ADD;
            end
            default: begin
                // ST_OUT: load result once output register is free
                if (!out_valid_next) begin
                    out_valid_next = 1'b1;
                    state_next     = takf_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= takf_pkg::ST_IDLE;
            pc_reg        <= 5'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                st_a_reg[i]   <= '0;
                st_b_reg[i]   <= '0;
                st_p00_reg[i] <= takf_pkg::ONE_Q;
                st_p01_reg[i] <= '0;
                st_p10_reg[i] <= '0;
                st_p11_reg[i] <= takf_pkg::ONE_Q;
            end
        end else begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == takf_pkg::ST_OUT && state_next == takf_pkg::ST_IDLE) begin
                // write back axis state
                st_a_reg[ax_reg]   <= rf_reg[R_A];
                st_b_reg[ax_reg]   <= rf_reg[R_B];
                st_p00_reg[ax_reg] <= rf_reg[R_P00];
                st_p01_reg[ax_reg] <= rf_reg[R_P01];
                st_p10_reg[ax_reg] <= rf_reg[R_P10];
                st_p11_reg[ax_reg] <= rf_reg[R_P11];
            end
        end
        if (state_reg == takf_pkg::ST_IDLE && s_tvalid && s_tready) begin
            ax_reg         <= ax_in;
            rf_reg[R_A]    <= st_a_reg[ax_in];
            rf_reg[R_B]    <= st_b_reg[ax_in];
            rf_reg[R_P00]  <= st_p00_reg[ax_in];
            rf_reg[R_P01]  <= st_p01_reg[ax_in];
            rf_reg[R_P10]  <= st_p10_reg[ax_in];
            rf_reg[R_P11]  <= st_p11_reg[ax_in];
            rf_reg[R_MEAS] <= s_tdata[48:1];
            rf_reg[R_RATE] <= s_tdata[96:49];
            rf_reg[R_Z]    <= '0;
        end else if (wr_en) begin
            rf_reg[u.dst] <= wr_val;
        end
        if (state_reg == takf_pkg::ST_OUT && state_next == takf_pkg::ST_IDLE) begin
            out_reg <= {rf_reg[R_X], rf_reg[R_A]};
        end
    end

    assign s_tready = (state_reg == takf_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
endmodule

FILE: hdl/takf_checker.sv
// ----------------------------------------------------------------------------
// Tilt-angle Kalman filter port checker
// Port-level properties of the filter unit, bound to the top level.
// ----------------------------------------------------------------------------
module takf_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata
);
    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // a taken request keeps the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after a request");

    // a request cannot produce a result in the next cycle
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

    // after reset the block is ready with nothing pending
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("bad reset state");
endmodule

bind tilt_angle_kalman_filter_unit takf_checker u_takf_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tilt-angle Kalman filter unit testbench
// Drives requests through several idle/stall phases and register settings,
// predicts each result with a bit-true Q16.32 model of the filter and checks
// every returned angle and rate in order.
// ----------------------------------------------------------------------------

class kalman_scoreboard;
    logic [46:0] qa, qb, rn, dt;
    logic signed [47:0] ang [2], bias [2], p00 [2], p01 [2], p10 [2], p11 [2];
    logic [47:0] exp_angle [$];
    logic [47:0] exp_rate [$];
    int errors;

    function new();
        errors = 0;
        qa = takf_pkg::QA_RST;
        qb = takf_pkg::QB_RST;
        rn = takf_pkg::RN_RST;
        dt = takf_pkg::DT_RST;
        for (int i = 0; i < 2; i++) begin
            ang[i] = 0;
            bias[i] = 0;
            p00[i] = 48'sh1_0000_0000;
            p01[i] = 0;
            p10[i] = 0;
            p11[i] = 48'sh1_0000_0000;
        end
    endfunction

    function void write_reg(logic [1:0] idx, logic [46:0] v);
        case (idx)
            takf_pkg::REG_QA: qa = v;
            takf_pkg::REG_QB: qb = v;
            takf_pkg::REG_RN: rn = v;
            default: dt = v;
        endcase
    endfunction

    function logic signed [47:0] clip(logic signed [65:0] v);
        if (v > 66'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (v < -66'sh8000_0000_0000) return -48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    function logic signed [47:0] sadd(logic signed [47:0] a, logic signed [47:0] b);
        return clip(66'(a) + 66'(b));
    endfunction

    function logic signed [47:0] ssub(logic signed [47:0] a, logic signed [47:0] b);
        return clip(66'(a) - 66'(b));
    endfunction

    // round the magnitude product to nearest, ties away from zero
    function logic signed [47:0] qmul(logic signed [47:0] a, logic signed [47:0] b);
        logic [95:0] m;
        logic signed [65:0] r;
        m = 96'(a < 0 ? -66'(a) : 66'(a)) * 96'(b < 0 ? -66'(b) : 66'(b));
        m = (m + 96'h8000_0000) >> 32;
        if (m > 96'h8000_0000_0000) m = 96'h8000_0000_0000;
        r = ((a < 0) != (b < 0)) ? -66'(m) : 66'(m);
        return clip(r);
    endfunction

    // truncate toward zero; zero divisor yields zero
    function logic signed [47:0] qdiv(logic signed [47:0] n, logic signed [47:0] d);
        logic [95:0] un, ud, q;
        logic signed [65:0] r;
        if (d == 0) return 0;
        un = 96'(n < 0 ? -66'(n) : 66'(n)) << 32;
        ud = 96'(d < 0 ? -66'(d) : 66'(d));
        q = un / ud;
        if (q > 96'h8000_0000_0000) q = 96'h8000_0000_0000;
        r = ((n < 0) != (d < 0)) ? -66'(q) : 66'(q);
        return clip(r);
    endfunction

    function void note_request(logic ax, logic signed [47:0] meas, logic signed [47:0] rate);
        logic signed [47:0] a, b, q0, q1, q2, q3, d0, d1, err, e, k0, k1, t0, t1, sdt;
        sdt = $signed({1'b0, dt});
        a = ang[ax]; b = bias[ax];
        q0 = p00[ax]; q1 = p01[ax]; q2 = p10[ax]; q3 = p11[ax];
        a = sadd(a, qmul(ssub(rate, b), sdt));
        d0 = ssub(ssub($signed({1'b0, qa}), q1), q2);
        d1 = ssub(0, q3);
        q0 = sadd(q0, qmul(d0, sdt));
        q1 = sadd(q1, qmul(d1, sdt));
        q2 = sadd(q2, qmul(d1, sdt));
        q3 = sadd(q3, qmul($signed({1'b0, qb}), sdt));
        err = ssub(meas, a);
        e = sadd($signed({1'b0, rn}), q0);
        k0 = qdiv(q0, e);
        k1 = qdiv(q2, e);
        t0 = q0; t1 = q1;
        q0 = ssub(q0, qmul(k0, t0));
        q1 = ssub(q1, qmul(k0, t1));
        q2 = ssub(q2, qmul(k1, t0));
        q3 = ssub(q3, qmul(k1, t1));
        a = sadd(a, qmul(k0, err));
        b = sadd(b, qmul(k1, err));
        ang[ax] = a; bias[ax] = b;
        p00[ax] = q0; p01[ax] = q1; p10[ax] = q2; p11[ax] = q3;
        exp_angle.push_back(a);
        exp_rate.push_back(ssub(rate, b));
    endfunction

    function void check_result(logic [95:0] d);
        if (exp_angle.size() == 0) begin
            $error("unexpected result %h", d);
            errors++;
            return;
        end
        if (d[47:0] !== exp_angle[0]) begin
            $error("filtered_angle expected %h actual %h", exp_angle[0], d[47:0]);
            errors++;
        end
        if (d[95:48] !== exp_rate[0]) begin
            $error("corrected_rate expected %h actual %h", exp_rate[0], d[95:48]);
            errors++;
        end
        void'(exp_angle.pop_front());
        void'(exp_rate.pop_front());
    endfunction
endclass

module testbench;
    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [103:0]  s_tdata = '0;   // axis[0], measured_angle[48:1], rate_in[96:49]
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [95:0]   m_tdata;        // filtered_angle[47:0], corrected_rate[95:48]
    logic          cfg_wen = 1'b0;
    logic [1:0]    cfg_index = takf_pkg::REG_QA;
    logic [46:0]   cfg_wdata = '0;

    kalman_scoreboard sb = new();
    int send_idle_pct = 0;     // percent of cycles the sender holds off
    int recv_stall_pct = 0;    // percent of cycles the receiver stalls
    int quiet_cycles = 0;
    bit timed_out = 1'b0;

    tilt_angle_kalman_filter_unit u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: stall at random, check every accepted result.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: fails the test if requests and results stop moving.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000 && !timed_out) begin
            timed_out = 1'b1;
            $display("testbench failed");
            $finish;
        end
    end

    // Hold off a random number of cycles, then present one request and wait for it.
    // tvalid stays high after acceptance; wait_idle or a hold-off drops it.
    task automatic send_request(logic ax, logic [47:0] meas, logic [47:0] rate);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, rate, meas, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(ax, $signed(meas), $signed(rate));
    endtask

    // Drain outstanding results and let the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.exp_angle.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [46:0] v);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        sb.write_reg(idx, v);
        @(posedge aclk);
    endtask

    // Random 48-bit value, mostly small angles/rates, sometimes an extreme or any bits.
    function automatic logic [47:0] rand_val();
        case ($urandom_range(9))
            0: return 48'({$urandom, $urandom});
            1: return $urandom_range(1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
            default: return 48'($signed(($urandom & 32'h00FF_FFFF) - 32'sh0080_0000)) <<< 12;
        endcase
    endfunction

    function automatic logic [46:0] rand_reg();
        case ($urandom_range(5))
            0: return 47'h7FFF_FFFF_FFFF;
            1: return 47'd1;
            2: return 47'({$urandom, $urandom});
            default: return 47'($urandom_range(32'h4000_0000, 1));
        endcase
    endfunction

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, both axes, tiny and huge noise settings.
        send_request(1'b0, 48'h0, 48'h0);
        send_request(1'b1, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
        send_request(1'b0, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
        send_request(1'b1, 48'hFFFF_FFFF_FFFF, 48'h0001_0000_0000);
        send_request(1'b0, 48'h002D_0000_0000, 48'hFFFF_FFFF_FFFF);
        send_request(1'b1, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
        // pause until every expected result has come
        wait_idle();
        write_reg(takf_pkg::REG_RN, 47'd1);
        write_reg(takf_pkg::REG_DT, 47'h7FFF_FFFF_FFFF);
        write_reg(takf_pkg::REG_QA, 47'h7FFF_FFFF_FFFF);
        write_reg(takf_pkg::REG_QB, 47'h0);
        for (int i = 0; i < 6; i++) send_request(i[0], rand_val(), rand_val());
        wait_idle();
        // zero sample period and zero Qa: divisor can reach zero
        write_reg(takf_pkg::REG_DT, 47'd0);
        write_reg(takf_pkg::REG_QA, 47'd0);
        write_reg(takf_pkg::REG_QB, 47'h7FFF_FFFF_FFFF);
        for (int i = 0; i < 6; i++) send_request(i[1], rand_val(), rand_val());
        wait_idle();
        write_reg(takf_pkg::REG_QA, takf_pkg::QA_RST);
        write_reg(takf_pkg::REG_QB, takf_pkg::QB_RST);
        write_reg(takf_pkg::REG_RN, takf_pkg::RN_RST);
        write_reg(takf_pkg::REG_DT, takf_pkg::DT_RST);

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (int i = 0; i < 215; i++)
                send_request(1'($urandom_range(1)), rand_val(), rand_val());
            wait_idle();
            if (ph != 7) write_reg(2'($urandom_range(3)), rand_reg());
            if (ph == 3) begin
                write_reg(takf_pkg::REG_QA, takf_pkg::QA_RST);
                write_reg(takf_pkg::REG_QB, takf_pkg::QB_RST);
                write_reg(takf_pkg::REG_RN, takf_pkg::RN_RST);
                write_reg(takf_pkg::REG_DT, takf_pkg::DT_RST);
            end
        end

        recv_stall_pct = 0;
        wait_idle();
        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.exp_angle.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hdl/takf_pkg.sv
hdl/takf_mul.sv
hdl/takf_div.sv
hdl/tilt_angle_kalman_filter_unit.sv
hdl/takf_checker.sv
tb/testbench.sv
